>>> rtl/aho_pkg.sv
// Package for the additive harmonic oscillator: payload structs, register
// indexes, reset values and the constant function that builds the sine table.
// Depends on nothing.
package aho_pkg;

  // Default sizes handed to the top level
  localparam int MaxHarmonicsDef = 6;
  localparam int SineDepthDef    = 1024;

  // Configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegSampleRate    = 8'd0;
  localparam logic [CfgIdxW-1:0] RegHarmonicCount = 8'd1;
  localparam logic [CfgIdxW-1:0] RegHarmonic0     = 8'd2;
  localparam int                 HarmRegs         = 6;

  // Register reset values
  localparam logic [17:0] SampleRateRst    = 18'd44100;
  localparam logic [2:0]  HarmonicCountRst = 3'd1;
  localparam logic [31:0] Harmonic0Rst     = 32'h1000_8000;

  // Pi/2 in Q30
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Output saturation limits
  localparam logic [20:0] OutMax = 21'h0F_FFFF;
  localparam logic [20:0] OutMin = 21'h10_0000;

  // Input request
  typedef struct packed {
    logic [23:0] fundamental_freq;
    logic [15:0] note_amplitude;
    logic [23:0] sample_index;
    logic        last_sample;
  } aho_in_t;

  // Result
  typedef struct packed {
    logic signed [20:0] sample_value;
    logic               last;
  } aho_out_t;

  // Sine of a Q30 angle as Q0.15 magnitude, Taylor series to the x^11 term
  function automatic logic [14:0] taylor_sine_q15(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    if (sum <= 64'sd0) begin
      return 15'd0;
    end
    v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[14:0];
  endfunction

endpackage

>>> rtl/additive_harmonic_oscillator.sv
// Additive harmonic oscillator: one sample per request, summed over harmonics; uses aho_pkg.
// Each request runs the harmonics in turn, count being harmonic_count clamped to MAX_HARMONICS;
// the phase of each goes through a 44-step and a clog2(4*depth)-step remainder loop on one
// compare-subtract unit. A new request is taken only when idle; start is taken again in the
// cycle done_o pulses and the receiver cannot stall. Reset restores register defaults; the
// sine ROM is constant.
module additive_harmonic_oscillator #(
  parameter int MAX_HARMONICS    = aho_pkg::MaxHarmonicsDef,
  parameter int SINE_TABLE_DEPTH = aho_pkg::SineDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  aho_pkg::aho_in_t             in_i,
  output logic                         done_o,
  output aho_pkg::aho_out_t            res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [aho_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [aho_pkg::CfgDataW-1:0] cfg_data_i
);

  // Derived sizes
  localparam int CW    = $clog2(MAX_HARMONICS + 1);
  localparam int HIW   = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int QW    = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int K4DW  = $clog2(4 * SINE_TABLE_DEPTH + 1);
  localparam int NLW   = 24 + K4DW;
  localparam int NHW   = 14 + K4DW;
  localparam int NW    = 38 + K4DW;
  localparam int StepW = 6;
  localparam int CfgIdxW_L = aho_pkg::CfgIdxW;

  localparam logic [23:0]      K4D  = 24'(4 * SINE_TABLE_DEPTH);
  localparam logic [QW-1:0]    DQ1  = QW'(SINE_TABLE_DEPTH);
  localparam logic [QW-1:0]    DQ2  = QW'(2 * SINE_TABLE_DEPTH);
  localparam logic [QW-1:0]    DQ3  = QW'(3 * SINE_TABLE_DEPTH);
  localparam logic [StepW-1:0] StepA = StepW'(43);
  localparam logic [StepW-1:0] StepB = StepW'(QW - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HARM,
    S_MUL_FM,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV_A,
    S_MUL_NL,
    S_MUL_NH,
    S_DIV_B,
    S_ROM_ADDR,
    S_ROM_READ,
    S_MUL_ACC,
    S_ACCUM,
    S_FINISH
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     h_q;
  logic [CW-1:0]     count_eff_q;
  logic [StepW-1:0]  step_q;
  logic              done_q;
  aho_pkg::aho_out_t res_q;

  // Configuration registers
  logic [17:0] rate_q;
  logic [2:0]  count_q;
  logic [31:0] harm_q [MAX_HARMONICS];

  // Datapath registers
  logic [23:0]        freq_q;
  logic [15:0]        amp_q;
  logic [23:0]        idx_q;
  logic               last_q;
  logic [17:0]        rate_eff_q;
  logic [39:0]        t_q;
  logic [43:0]        lo_q;
  logic [37:0]        rem_q;
  logic [NLW-1:0]     nl_q;
  logic [37:0]        pr_q;
  logic [NW-1:0]      dsh_q;
  logic [QW-1:0]      qt_q;
  logic [AW-1:0]      rom_addr_q;
  logic               neg_q;
  logic [14:0]        sine_q;
  logic [31:0]        gain_q;
  logic [46:0]        term_q;
  logic signed [51:0] acc_q;

  logic              accept;
  logic [31:0]       hw;
  logic [31:0]       mul_a;
  logic [23:0]       mul_b;
  logic [55:0]       mul_p;
  logic [43:0]       prodh;
  logic [NW-1:0]     n_full;
  logic [NW-1:0]     n_shr;
  logic [38:0]       trial;
  logic [38:0]       div_v;
  logic [38:0]       diff;
  logic              ge;
  logic [37:0]       pr_step;
  logic [1:0]        quad;
  logic [QW-1:0]     r_off;
  logic [QW-1:0]     addr_full;
  logic [CW-1:0]     count_clamp;
  logic [CfgIdxW_L-1:0] cfg_k;
  logic [51:0]       mag;
  logic [51:0]       rnd_sum;
  logic [21:0]       rnd;
  logic [21:0]       rnd_neg;
  logic [20:0]       sat_val;
  logic [14:0]       sine_rom [SINE_TABLE_DEPTH + 1];

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = res_q;

  assign hw = harm_q[h_q[HIW-1:0]];

  // Build the quarter-wave sine ROM from constants
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam logic [63:0] X = (64'(k) * aho_pkg::HalfPiQ30 + 64'(SINE_TABLE_DEPTH / 2))
                                / 64'(SINE_TABLE_DEPTH);
    assign sine_rom[k] = aho_pkg::taylor_sine_q15(X);
  end

  // Read the sine ROM, registered
  always_ff @(posedge clk_i) begin
    sine_q <= sine_rom[rom_addr_q];
  end

  // Clamp the harmonic count to the supported number
  assign count_clamp = (count_q > 3'(MAX_HARMONICS)) ? CW'(MAX_HARMONICS) : CW'(count_q);

  // Decode the harmonic slot of a configuration write
  assign cfg_k = cfg_index_i - aho_pkg::RegHarmonic0;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= aho_pkg::SampleRateRst;
      count_q <= aho_pkg::HarmonicCountRst;
      for (int i = 0; i < MAX_HARMONICS; i++) begin
        harm_q[i] <= (i == 0) ? aho_pkg::Harmonic0Rst : 32'd0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == aho_pkg::RegSampleRate) begin
        rate_q <= cfg_data_i[17:0];
      end else if (cfg_index_i == aho_pkg::RegHarmonicCount) begin
        count_q <= cfg_data_i[2:0];
      end else if (cfg_index_i >= aho_pkg::RegHarmonic0 &&
                   cfg_k < CfgIdxW_L'(MAX_HARMONICS)) begin
        harm_q[cfg_k[HIW-1:0]] <= cfg_data_i;
      end
    end
  end

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 24'd0;
    case (state_q)
      S_MUL_FM: begin
        mul_a = {16'd0, hw[31:16]};
        mul_b = freq_q;
      end
      S_MUL_LO: begin
        mul_a = {12'd0, t_q[19:0]};
        mul_b = idx_q;
      end
      S_MUL_HI: begin
        mul_a = {12'd0, t_q[39:20]};
        mul_b = idx_q;
      end
      S_MUL_NL: begin
        mul_a = {8'd0, rem_q[23:0]};
        mul_b = K4D;
      end
      S_MUL_NH: begin
        mul_a = {18'd0, rem_q[37:24]};
        mul_b = K4D;
      end
      S_ROM_READ: begin
        mul_a = {16'd0, amp_q};
        mul_b = {8'd0, hw[15:0]};
      end
      S_MUL_ACC: begin
        mul_a = gain_q;
        mul_b = {9'd0, sine_q};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 24'd0;
      end
    endcase
  end

  assign mul_p = {24'd0, mul_a} * {32'd0, mul_b};

  // Phase product above bit 20, and the scaled remainder for the index divide
  assign prodh  = mul_p[43:0] + {20'd0, lo_q[43:20]};
  assign n_full = {mul_p[NHW-1:0], 24'd0} + NW'(nl_q);
  assign n_shr  = n_full >> QW;

  // Shared compare-subtract step of the remainder loops
  assign trial   = {pr_q, dsh_q[NW-1]};
  assign div_v   = (state_q == S_DIV_A) ? {21'd0, rate_eff_q} : {1'b0, rate_eff_q, 20'd0};
  assign ge      = (trial >= div_v);
  assign diff    = trial - div_v;
  assign pr_step = ge ? diff[37:0] : trial[37:0];

  // Split the table index into quadrant and offset
  always_comb begin
    if (qt_q >= DQ3) begin
      quad  = 2'd3;
      r_off = qt_q - DQ3;
    end else if (qt_q >= DQ2) begin
      quad  = 2'd2;
      r_off = qt_q - DQ2;
    end else if (qt_q >= DQ1) begin
      quad  = 2'd1;
      r_off = qt_q - DQ1;
    end else begin
      quad  = 2'd0;
      r_off = qt_q;
    end
    addr_full = quad[0] ? (DQ1 - r_off) : r_off;
  end

  // Round half away from zero, then saturate
  always_comb begin
    mag     = acc_q[51] ? 52'(-acc_q) : 52'(acc_q);
    rnd_sum = mag + 52'd536870912;
    rnd     = rnd_sum[51:30];
    rnd_neg = -rnd;
    if (!acc_q[51]) begin
      sat_val = (rnd > 22'({1'b0, aho_pkg::OutMax})) ? aho_pkg::OutMax : rnd[20:0];
    end else begin
      sat_val = (rnd > 22'd1048576) ? aho_pkg::OutMin : rnd_neg[20:0];
    end
  end

  // Advance the datapath under the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          freq_q     <= in_i.fundamental_freq;
          amp_q      <= in_i.note_amplitude;
          idx_q      <= in_i.sample_index;
          last_q     <= in_i.last_sample;
          rate_eff_q <= (rate_q == 18'd0) ? 18'd1 : rate_q;
          acc_q      <= 52'sd0;
        end
      end
      S_MUL_FM: t_q <= mul_p[39:0];
      S_MUL_LO: lo_q <= mul_p[43:0];
      S_MUL_HI: begin
        pr_q  <= 38'd0;
        dsh_q <= {prodh, {(NW - 44){1'b0}}};
      end
      S_DIV_A: begin
        pr_q  <= pr_step;
        dsh_q <= {dsh_q[NW-2:0], 1'b0};
        rem_q <= {pr_step[17:0], lo_q[19:0]};
      end
      S_MUL_NL: nl_q <= mul_p[NLW-1:0];
      S_MUL_NH: begin
        pr_q  <= n_shr[37:0];
        dsh_q <= n_full << (NW - QW);
      end
      S_DIV_B: begin
        pr_q  <= pr_step;
        dsh_q <= {dsh_q[NW-2:0], 1'b0};
        qt_q  <= {qt_q[QW-2:0], ge};
      end
      S_ROM_ADDR: begin
        rom_addr_q <= addr_full[AW-1:0];
        neg_q      <= quad[1];
      end
      S_ROM_READ: gain_q <= mul_p[31:0];
      S_MUL_ACC:  term_q <= mul_p[46:0];
      S_ACCUM: begin
        if (neg_q) begin
          acc_q <= acc_q - $signed({5'd0, term_q});
        end else begin
          acc_q <= acc_q + $signed({5'd0, term_q});
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence the harmonics and hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      h_q         <= '0;
      count_eff_q <= '0;
      step_q      <= '0;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            h_q         <= '0;
            count_eff_q <= count_clamp;
            state_q     <= S_HARM;
          end
        end
        S_HARM: begin
          state_q <= (h_q == count_eff_q) ? S_FINISH : S_MUL_FM;
        end
        S_MUL_FM: state_q <= S_MUL_LO;
        S_MUL_LO: state_q <= S_MUL_HI;
        S_MUL_HI: begin
          step_q  <= StepA;
          state_q <= S_DIV_A;
        end
        S_DIV_A: begin
          step_q <= step_q - StepW'(1);
          if (step_q == '0) begin
            state_q <= S_MUL_NL;
          end
        end
        S_MUL_NL: state_q <= S_MUL_NH;
        S_MUL_NH: begin
          step_q  <= StepB;
          state_q <= S_DIV_B;
        end
        S_DIV_B: begin
          step_q <= step_q - StepW'(1);
          if (step_q == '0) begin
            state_q <= S_ROM_ADDR;
          end
        end
        S_ROM_ADDR: state_q <= S_ROM_READ;
        S_ROM_READ: state_q <= S_MUL_ACC;
        S_MUL_ACC:  state_q <= S_ACCUM;
        S_ACCUM: begin
          h_q     <= h_q + CW'(1);
          state_q <= S_HARM;
        end
        S_FINISH: begin
          res_q.sample_value <= $signed(sat_val);
          res_q.last         <= last_q;
          done_q             <= 1'b1;
          state_q            <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> bench/additive_harmonic_oscillator_tb.sv
// Testbench for the additive harmonic oscillator: directed table, then random notes.
// Samples are checked against a built-in model of the sine bank or an expected zero.
// Depends on aho_pkg and additive_harmonic_oscillator.
module additive_harmonic_oscillator_tb;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 6;
  localparam int SineDepth     = aho_pkg::SineDepthDef;
  localparam int MaxHarm       = aho_pkg::MaxHarmonicsDef;
  localparam int NumPhases     = 10;
  localparam int PhaseRequests = 100;
  localparam int DrainCycles   = 400;
  localparam int TimeoutCycles = 2_500_000;
  localparam longint SampleMax = 1048575;
  localparam longint SampleMin = -1048576;

  // One row of the directed table: a register write or a request
  typedef struct packed {
    logic                          is_reg;
    logic [aho_pkg::CfgIdxW-1:0]   reg_idx;
    logic [aho_pkg::CfgDataW-1:0]  reg_data;
    aho_pkg::aho_in_t              req;
    logic                          expect_zero;
  } stim_row_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start       = 1'b0;
  logic                         busy;
  aho_pkg::aho_in_t             in_i        = '0;
  logic                         done_o;
  aho_pkg::aho_out_t            res_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [aho_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [aho_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  // Model copy of the registers and the quarter-wave table
  logic [17:0] rate_reg;
  logic [2:0]  count_reg;
  logic [31:0] harm_reg [aho_pkg::HarmRegs];
  int          sine_tab [SineDepth+1];

  aho_pkg::aho_out_t expected_samples [$];
  stim_row_t         dir_rows [$];
  int                burst_left;
  int                requests_sent;
  int                samples_checked;
  int                reg_writes;
  int                mismatches;

  additive_harmonic_oscillator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkPeriod/2) clk_i = ~clk_i;

  // Sine of a Q30 angle in [0, pi/2], Q0.15, truncated Taylor terms up to x^11
  function automatic int quarter_sine_q15(input longint unsigned angle);
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    longint          v;
    int              n;
    sq   = (angle * angle) >> 30;
    term = angle;
    acc  = longint'(angle);
    for (n = 1; n <= 5; n++) begin
      term = ((term * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc <= 0) begin
      return 0;
    end
    v = (acc * 32767 + 536870912) >>> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return int'(v);
  endfunction

  // Fold a full-circle table index onto the quarter wave
  function automatic int sine_at_index(input longint unsigned idx);
    longint unsigned quad;
    longint unsigned off;
    int              s;
    quad = (idx / SineDepth) & 3;
    off  = idx % SineDepth;
    s    = quad[0] ? sine_tab[SineDepth - int'(off)] : sine_tab[int'(off)];
    return quad[1] ? -s : s;
  endfunction

  // Sum the harmonic sines for one request, round once and saturate
  function automatic aho_pkg::aho_out_t predict_sample(input aho_pkg::aho_in_t req);
    longint unsigned   rate;
    longint unsigned   modulus;
    longint unsigned   prod;
    longint unsigned   phase;
    longint            acc;
    longint            mag;
    longint            v;
    longint            gain;
    int                n_harm;
    int                h;
    aho_pkg::aho_out_t r;
    rate    = (rate_reg == 18'd0) ? 1 : longint'(rate_reg);
    modulus = rate << 20;
    n_harm  = (int'(count_reg) > MaxHarm) ? MaxHarm : int'(count_reg);
    acc     = 0;
    for (h = 0; h < n_harm && h < aho_pkg::HarmRegs; h++) begin
      prod  = longint'(req.fundamental_freq);
      prod  = prod * longint'(harm_reg[h][31:16]);
      prod  = prod * longint'(req.sample_index);
      phase = ((prod % modulus) * (4 * SineDepth)) / modulus;
      gain  = longint'(req.note_amplitude) * longint'(harm_reg[h][15:0]);
      acc   = acc + gain * longint'(sine_at_index(phase));
    end
    mag = (acc < 0) ? -acc : acc;
    mag = (mag + 536870912) >>> 30;
    v   = (acc < 0) ? -mag : mag;
    if (v > SampleMax) begin
      v = SampleMax;
    end
    if (v < SampleMin) begin
      v = SampleMin;
    end
    r.sample_value = 21'(v);
    r.last         = req.last_sample;
    return r;
  endfunction

  // Mirror a register write into the model; unknown indexes drop
  function automatic void apply_reg_write(input logic [aho_pkg::CfgIdxW-1:0] idx,
                                          input logic [aho_pkg::CfgDataW-1:0] data);
    if (idx == aho_pkg::RegSampleRate) begin
      rate_reg = data[17:0];
    end else if (idx == aho_pkg::RegHarmonicCount) begin
      count_reg = data[2:0];
    end else if (idx >= aho_pkg::RegHarmonic0 &&
                 int'(idx) < int'(aho_pkg::RegHarmonic0) + aho_pkg::HarmRegs) begin
      harm_reg[idx - aho_pkg::RegHarmonic0] = data;
    end
  endfunction

  function automatic stim_row_t reg_row(input logic [aho_pkg::CfgIdxW-1:0] idx,
                                        input logic [aho_pkg::CfgDataW-1:0] data);
    stim_row_t row;
    row          = '0;
    row.is_reg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic stim_row_t req_row(input logic [23:0] f, input logic [15:0] a,
                                        input logic [23:0] ix, input logic l,
                                        input logic zero);
    stim_row_t row;
    row                      = '0;
    row.req.fundamental_freq = f;
    row.req.note_amplitude   = a;
    row.req.sample_index     = ix;
    row.req.last_sample      = l;
    row.expect_zero          = zero;
    return row;
  endfunction

  // Hold start low until every sample is back and the block is idle
  task automatic wait_until_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0 || busy) begin
      @(posedge clk_i);
    end
  endtask

  // Write one register while the block is idle
  task automatic write_register(input logic [aho_pkg::CfgIdxW-1:0] idx,
                                input logic [aho_pkg::CfgDataW-1:0] data);
    wait_until_quiet();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    apply_reg_write(idx, data);
    reg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Issue one request, record its sample, then idle for a random gap at most burst ends
  task automatic send_request(input aho_pkg::aho_in_t req, input logic expect_zero);
    aho_pkg::aho_out_t want;
    int                gap;
    start <= 1'b1;
    in_i  <= req;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    if (expect_zero) begin
      want.sample_value = '0;
      want.last         = req.last_sample;
    end else begin
      want = predict_sample(req);
    end
    expected_samples.push_back(want);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Check each sample against the oldest outstanding request
  always @(posedge clk_i) begin : check_samples
    aho_pkg::aho_out_t want;
    if (rst_ni && done_o) begin
      if (expected_samples.size() == 0) begin
        $error("sample with no request outstanding: sample_value %0d last %0b",
               res_o.sample_value, res_o.last);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (res_o.sample_value !== want.sample_value) begin
          $error("sample_value: expected %0d, got %0d", want.sample_value,
                 res_o.sample_value);
          mismatches++;
        end
        if (res_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res_o.last);
          mismatches++;
        end
      end
    end
  end

  // Build the quarter-wave table and the register defaults
  initial begin : model_init
    int k;
    for (k = 0; k <= SineDepth; k++) begin
      sine_tab[k] = quarter_sine_q15((longint'(k) * longint'(aho_pkg::HalfPiQ30)
                                      + SineDepth / 2) / SineDepth);
    end
    rate_reg  = aho_pkg::SampleRateRst;
    count_reg = aho_pkg::HarmonicCountRst;
    for (k = 0; k < aho_pkg::HarmRegs; k++) begin
      harm_reg[k] = '0;
    end
    harm_reg[0] = aho_pkg::Harmonic0Rst;
  end

  initial begin : stimulus
    aho_pkg::aho_in_t req;
    logic [17:0]      rate;
    logic [15:0]      mult;
    logic [23:0]      base;
    int               phase;
    int               n;
    int               k;
    int               len;
    int               h;

    // Directed rows: reset settings, then each special case
    dir_rows.push_back(req_row(24'h123456, 16'h8000, 24'd0,      1'b0, 1'b1));
    dir_rows.push_back(req_row(24'hFFFFFF, 16'h0000, 24'hFFFFFF, 1'b1, 1'b1));
    dir_rows.push_back(req_row(24'h000000, 16'hFFFF, 24'hFFFFFF, 1'b0, 1'b1));
    dir_rows.push_back(req_row(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0));
    dir_rows.push_back(req_row(24'd112640, 16'h7FFF, 24'd25,     1'b0, 1'b0));
    dir_rows.push_back(req_row(24'd112640, 16'h7FFF, 24'd50,     1'b0, 1'b0));
    // no harmonics summed
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonicCount, 32'd0));
    dir_rows.push_back(req_row(24'hFFFFFF, 16'hFFFF, 24'd12345,  1'b1, 1'b1));
    // zero rate acts as one, count above the maximum clamps
    dir_rows.push_back(reg_row(aho_pkg::RegSampleRate, 32'd0));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonicCount, 32'd7));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonic0,        32'hFFFF_FFFF));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonic0 + 8'd1, 32'h2000_FFFF));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonic0 + 8'd2, 32'h3000_7FFF));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonic0 + 8'd3, 32'h0001_0001));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonic0 + 8'd4, 32'h8000_4000));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonic0 + 8'd5, 32'hFFFF_0000));
    dir_rows.push_back(req_row(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0));
    dir_rows.push_back(req_row(24'hABCDEF, 16'h5555, 24'h00F00F, 1'b0, 1'b0));
    // writes past the register list leave the settings alone
    dir_rows.push_back(reg_row(8'd8,   32'h0000_0000));
    dir_rows.push_back(reg_row(8'd255, 32'hFFFF_FFFF));
    dir_rows.push_back(req_row(24'h000100, 16'hFFFF, 24'h000003, 1'b1, 1'b0));
    dir_rows.push_back(reg_row(aho_pkg::RegSampleRate, 32'd192000));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonicCount, 32'd6));
    dir_rows.push_back(req_row(24'd112640, 16'hFFFF, 24'd48000,  1'b0, 1'b0));
    dir_rows.push_back(req_row(24'hFFFFFF, 16'hFFFF, 24'h7FFFFF, 1'b1, 1'b0));
    // widest rate field, single harmonic with zero multiplier
    dir_rows.push_back(reg_row(aho_pkg::RegSampleRate, 32'h0003_FFFF));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonicCount, 32'd1));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonic0, 32'h0000_FFFF));
    dir_rows.push_back(req_row(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0, 1'b1));
    dir_rows.push_back(reg_row(aho_pkg::RegSampleRate, 32'd1));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonicCount, 32'd6));
    dir_rows.push_back(reg_row(aho_pkg::RegHarmonic0, 32'h1000_8000));
    dir_rows.push_back(req_row(24'd1,      16'h8000, 24'd1,      1'b0, 1'b0));
    dir_rows.push_back(req_row(24'h800000, 16'h8000, 24'h800000, 1'b1, 1'b0));

    // Hold reset, then release
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (n = 0; n < dir_rows.size(); n++) begin
      if (dir_rows[n].is_reg) begin
        write_register(dir_rows[n].reg_idx, dir_rows[n].reg_data);
      end else begin
        send_request(dir_rows[n].req, dir_rows[n].expect_zero);
      end
    end

    // Random phases: fresh settings, then notes mixed with stray requests
    for (phase = 0; phase < NumPhases; phase++) begin
      case ($urandom_range(0, 5))
        0:       rate = 18'd44100;
        1:       rate = 18'd48000;
        2:       rate = 18'd96000;
        3:       rate = 18'd192000;
        4:       rate = 18'($urandom_range(1, 192000));
        default: rate = $urandom_range(0, 1) ? 18'd0 : 18'h3FFFF;
      endcase
      write_register(aho_pkg::RegSampleRate, ($urandom() & 32'hFFFC_0000) | 32'(rate));
      write_register(aho_pkg::RegHarmonicCount,
                     ($urandom() & 32'hFFFF_FFF8) | 32'($urandom_range(0, 7)));
      for (h = 0; h < aho_pkg::HarmRegs; h++) begin
        mult = $urandom_range(0, 1) ? 16'($urandom_range(1, 8) << 12) : 16'($urandom());
        write_register(aho_pkg::RegHarmonic0 + 8'(h), {mult, 16'($urandom())});
      end
      if ($urandom_range(0, 2) == 0) begin
        write_register(8'($urandom_range(int'(aho_pkg::RegHarmonic0) + aho_pkg::HarmRegs,
                                         255)), $urandom());
      end

      n = 0;
      while (n < PhaseRequests) begin
        if ($urandom_range(0, 4) == 0) begin
          req.fundamental_freq = 24'($urandom());
          req.note_amplitude   = 16'($urandom());
          req.sample_index     = 24'($urandom());
          req.last_sample      = 1'($urandom());
          send_request(req, 1'b0);
          n++;
        end else begin
          // advance one note sample by sample, flag its final sample
          req.fundamental_freq = 24'($urandom_range(20 * 256, 20000 * 256));
          req.note_amplitude   = 16'($urandom());
          base = $urandom_range(0, 1) ? 24'd0 : 24'($urandom());
          len  = $urandom_range(1, 24);
          for (k = 0; k < len; k++) begin
            req.sample_index = base + 24'(k);
            req.last_sample  = (k == len - 1);
            send_request(req, 1'b0);
            n++;
          end
        end
      end
    end

    // Drain outstanding samples, then watch for strays
    wait_until_quiet();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d samples from %0d requests over %0d register writes",
             samples_checked, requests_sent, reg_writes);
    $display("Covered %0d directed rows and %0d random setting phases",
             dir_rows.size(), NumPhases);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Drop the run if it hangs
  initial begin : watchdog
    #(longint'(TimeoutCycles) * ClkPeriod);
    $display("Regression FAIL");
    $finish;
  end

endmodule
